FILE: hw/rtl/rrw_pkg.sv
// Shared types and constants for the reorder receive window.
// Holds the command and status structures between controller and datapath.
// No dependencies.
package rrw_pkg;

    localparam int SEQ_W      = 32;
    localparam int LEN_W      = 11;
    localparam int WIN_W      = 16;
    localparam int KIND_W     = 3;
    localparam int SLOT_OUT_W = 4;
    localparam int CREDIT_W   = 16;
    localparam int REM_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CREDIT_W-1:0] CREDIT_MAX = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_SEQ = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_CAP  = 4'd1;

    localparam logic [KIND_W-1:0] KIND_DELIVER  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DRAIN    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_STORE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ACK      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NO_SPACE = 3'd4;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd5;

    typedef struct packed {
        logic              capture;
        logic              div_start;
        logic              emit;
        logic [KIND_W-1:0] kind;
        logic              use_slot_len;
        logic              last;
    } t_cmd;

    typedef struct packed {
        logic dist_zero;
        logic dist_ahead;
        logic in_range;
        logic fits_in;
        logic fits_slot;
        logic occ_exp;
        logic occ_slot;
        logic credit_short;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

FILE: hw/rtl/rrw_controller.sv
// Sequencing state machine for the reorder receive window.
// Depends on rrw_pkg for the command and status structures.
module rrw_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rrw_pkg::t_status i_status,
    output rrw_pkg::t_cmd    o_cmd
);
    import rrw_pkg::*;

    localparam logic [2:0] ST_IDLE        = 3'd0;
    localparam logic [2:0] ST_CLASSIFY    = 3'd1;
    localparam logic [2:0] ST_DIVIDE      = 3'd2;
    localparam logic [2:0] ST_SLOT        = 3'd3;
    localparam logic [2:0] ST_STORE_ACK   = 3'd4;
    localparam logic [2:0] ST_DRAIN_CHECK = 3'd5;
    localparam logic [2:0] ST_DRAIN_EMIT  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY: begin
                if (i_status.dist_zero) begin
                    if (i_status.out_free) begin
                        o_cmd.emit = 1'b1;
                        if (i_status.fits_in) begin
                            o_cmd.kind = KIND_DELIVER;
                            n_state    = ST_DRAIN_CHECK;
                        end else begin
                            o_cmd.kind = KIND_FULL;
                            o_cmd.last = 1'b1;
                            n_state    = ST_IDLE;
                        end
                    end
                end else if (i_status.dist_ahead) begin
                    if (i_status.in_range) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = ST_DIVIDE;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_ACK;
                    o_cmd.last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_DIVIDE: begin
                if (i_status.div_done) begin
                    n_state = ST_SLOT;
                end
            end
            ST_SLOT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.occ_slot) begin
                        o_cmd.kind = KIND_ACK;
                        o_cmd.last = 1'b1;
                        n_state    = ST_IDLE;
                    end else if (i_status.credit_short) begin
                        o_cmd.kind = KIND_NO_SPACE;
                        o_cmd.last = 1'b1;
                        n_state    = ST_IDLE;
                    end else begin
                        o_cmd.kind = KIND_STORE;
                        n_state    = ST_STORE_ACK;
                    end
                end
            end
            ST_STORE_ACK: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_ACK;
                    o_cmd.last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_DRAIN_CHECK: begin
                if (i_status.occ_exp) begin
                    n_state = ST_DRAIN_EMIT;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_ACK;
                    o_cmd.last = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_DRAIN_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.fits_slot) begin
                        o_cmd.kind = KIND_DRAIN;
                        n_state    = ST_DRAIN_CHECK;
                    end else begin
                        o_cmd.kind         = KIND_FULL;
                        o_cmd.use_slot_len = 1'b1;
                        o_cmd.last         = 1'b1;
                        n_state            = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hw/rtl/rrw_datapath.sv
// Datapath of the reorder receive window: stream state, slot table, slot divider and
// the result register. Depends on rrw_pkg; driven by rrw_controller commands.
module rrw_datapath #(
    parameter int WINDOW_PACKETS = 8,
    parameter int PAYLOAD_BYTES  = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rrw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rrw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [rrw_pkg::SEQ_W-1:0]         i_packet_sequence,
    input  logic [rrw_pkg::LEN_W-1:0]         i_payload_length,
    input  logic [rrw_pkg::WIN_W-1:0]         i_peer_advertised_window,
    input  rrw_pkg::t_cmd                     i_cmd,
    output rrw_pkg::t_status                  o_status,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [rrw_pkg::KIND_W-1:0]        o_result_kind,
    output logic [rrw_pkg::SLOT_OUT_W-1:0]    o_slot_index,
    output logic [rrw_pkg::LEN_W-1:0]         o_move_length,
    output logic [rrw_pkg::SEQ_W-1:0]         o_write_offset,
    output logic [rrw_pkg::SEQ_W-1:0]         o_ack_number,
    output logic [rrw_pkg::CREDIT_W-1:0]      o_advertised_space,
    output logic                              o_peer_window_changed,
    output logic                              o_last_of_run
);
    import rrw_pkg::*;

    localparam int SLOT_COUNT = 2 * WINDOW_PACKETS;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int QUOT_W     = $clog2(SLOT_COUNT + 1);
    localparam int NUM_W      = $clog2((SLOT_COUNT + 1) * PAYLOAD_BYTES + 1);
    localparam int SUM_W      = SLOT_W + 2;
    localparam logic [SEQ_W-1:0]  SLOT_RANGE = SEQ_W'(SLOT_COUNT * PAYLOAD_BYTES);
    localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(SLOT_COUNT - 1);

    logic [SEQ_W-1:0]      r_init_seq;
    logic [SEQ_W-1:0]      r_out_cap;
    logic [SEQ_W-1:0]      r_expected;
    logic [SEQ_W-1:0]      r_delta;
    logic [SLOT_W-1:0]     r_q;
    logic [REM_W-1:0]      r_rem;
    logic [CREDIT_W-1:0]   r_credit;
    logic [SEQ_W-1:0]      r_delivered;
    logic [WIN_W-1:0]      r_peer;
    logic [SLOT_COUNT-1:0] r_occ;

    logic [SEQ_W-1:0]      r_seq;
    logic [LEN_W-1:0]      r_len;
    logic                  r_win_flag;

    logic [LEN_W-1:0]      r_mem [SLOT_COUNT];
    logic [LEN_W-1:0]      r_rd_len;

    logic [NUM_W-1:0]      r_num;
    logic [QUOT_W-1:0]     r_quot;
    logic                  r_busy;
    logic [SLOT_W-1:0]     r_base;

    logic                  r_out_valid;

    logic [SEQ_W-1:0]      cfg_init;
    logic [SEQ_W-1:0]      cfg_cap;
    logic [CREDIT_W-1:0]   cfg_credit;
    logic [LEN_W-1:0]      clamp_len;
    logic [SEQ_W-1:0]      seq_gap;
    logic [SEQ_W-1:0]      seq_off;
    logic                  wrapped;
    logic [QUOT_W-1:0]     quot_calc;
    logic [SUM_W-1:0]      slot_sum;
    logic [SLOT_W-1:0]     slot_calc;
    logic [SLOT_W+3:0]     slot_ext;
    logic [LEN_W-1:0]      adv_len;
    logic [SEQ_W:0]        adv_delta;
    logic [REM_W:0]        adv_rem;
    logic [SLOT_W-1:0]     q_inc;
    logic [SEQ_W-1:0]      n_delta;
    logic [SLOT_W-1:0]     n_q;
    logic [REM_W-1:0]      n_rem;
    logic [SEQ_W-1:0]      n_expected;
    logic [SEQ_W-1:0]      n_delivered;
    logic [CREDIT_W:0]     drain_sum;
    logic [CREDIT_W-1:0]   n_credit;
    logic [SLOT_W-1:0]     n_slot;
    logic [LEN_W-1:0]      n_move;
    logic [SEQ_W-1:0]      n_offset;
    logic                  advance;

    assign cfg_init   = (i_cfg_index == REG_INIT_SEQ) ? i_cfg_data : r_init_seq;
    assign cfg_cap    = (i_cfg_index == REG_OUT_CAP) ? i_cfg_data : r_out_cap;
    assign cfg_credit = (cfg_cap > SEQ_W'(CREDIT_MAX)) ? CREDIT_MAX : cfg_cap[CREDIT_W-1:0];

    assign clamp_len = (17'(i_payload_length) > 17'(PAYLOAD_BYTES)) ?
                       LEN_W'(PAYLOAD_BYTES) : i_payload_length;

    assign seq_gap = r_seq - r_expected;
    assign seq_off = r_seq - r_init_seq;
    assign wrapped = (seq_off < r_delta);

    // The quotient is at most SLOT_COUNT, so it is found by comparing against every multiple.
    always_comb begin
        quot_calc = '0;
        for (int k = 1; k <= SLOT_COUNT; k++) begin
            if (r_num >= NUM_W'(k * PAYLOAD_BYTES)) begin
                quot_calc = QUOT_W'(k);
            end
        end
    end

    assign slot_sum  = SUM_W'(r_base) + SUM_W'(r_quot);
    assign slot_calc = (slot_sum >= SUM_W'(SLOT_COUNT)) ?
                       SLOT_W'(slot_sum - SUM_W'(SLOT_COUNT)) : SLOT_W'(slot_sum);

    assign adv_len   = (i_cmd.kind == KIND_DRAIN) ? r_rd_len : r_len;
    assign adv_delta = (SEQ_W + 1)'(r_delta) + (SEQ_W + 1)'(adv_len);
    assign adv_rem   = (REM_W + 1)'(r_rem) + (REM_W + 1)'(adv_len);
    assign q_inc     = (r_q == SLOT_LAST) ? '0 : r_q + 1'b1;
    assign n_delta   = adv_delta[SEQ_W-1:0];
    assign n_expected  = r_expected + SEQ_W'(adv_len);
    assign n_delivered = r_delivered + SEQ_W'(adv_len);
    assign drain_sum   = (CREDIT_W + 1)'(r_credit) + (CREDIT_W + 1)'(r_rd_len);
    assign advance     = (i_cmd.kind == KIND_DELIVER) || (i_cmd.kind == KIND_DRAIN);

    always_comb begin
        if (adv_delta[SEQ_W]) begin
            n_q   = '0;
            n_rem = adv_delta[REM_W-1:0];
        end else if (adv_rem >= (REM_W + 1)'(PAYLOAD_BYTES)) begin
            n_q   = q_inc;
            n_rem = REM_W'(adv_rem - (REM_W + 1)'(PAYLOAD_BYTES));
        end else begin
            n_q   = r_q;
            n_rem = adv_rem[REM_W-1:0];
        end
    end

    always_comb begin
        n_credit = r_credit;
        n_slot   = '0;
        n_move   = '0;
        n_offset = '0;
        case (i_cmd.kind)
            KIND_DELIVER: begin
                n_credit = (r_credit > CREDIT_W'(r_len)) ? r_credit - CREDIT_W'(r_len) : '0;
                n_move   = r_len;
                n_offset = r_delivered;
            end
            KIND_DRAIN: begin
                n_credit = drain_sum[CREDIT_W] ? CREDIT_MAX : drain_sum[CREDIT_W-1:0];
                n_slot   = r_q;
                n_move   = r_rd_len;
                n_offset = r_delivered;
            end
            KIND_STORE: begin
                n_credit = r_credit - CREDIT_W'(r_len);
                n_slot   = slot_calc;
                n_move   = r_len;
            end
            KIND_NO_SPACE: begin
                n_move = r_len;
            end
            KIND_FULL: begin
                n_move = i_cmd.use_slot_len ? r_rd_len : r_len;
            end
            default: begin
                n_move = '0;
            end
        endcase
    end

    assign slot_ext = (SLOT_W + 4)'(n_slot);

    always_comb begin
        o_status.dist_zero    = (seq_gap == '0);
        o_status.dist_ahead   = !seq_gap[SEQ_W-1] && (seq_gap != '0);
        o_status.in_range     = (seq_gap < SLOT_RANGE);
        o_status.fits_in      = ((SEQ_W + 1)'(r_delivered) + (SEQ_W + 1)'(r_len))
                                <= (SEQ_W + 1)'(r_out_cap);
        o_status.fits_slot    = ((SEQ_W + 1)'(r_delivered) + (SEQ_W + 1)'(r_rd_len))
                                <= (SEQ_W + 1)'(r_out_cap);
        o_status.occ_exp      = r_occ[r_q];
        o_status.occ_slot     = r_occ[slot_calc];
        o_status.credit_short = (r_credit < CREDIT_W'(r_len));
        o_status.div_done     = !r_busy;
        o_status.out_free     = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_seq  <= '0;
            r_out_cap   <= SEQ_W'(CREDIT_MAX);
            r_expected  <= '0;
            r_delta     <= '0;
            r_q         <= '0;
            r_rem       <= '0;
            r_credit    <= CREDIT_MAX;
            r_delivered <= '0;
            r_peer      <= '0;
            r_occ       <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we && ((i_cfg_index == REG_INIT_SEQ) || (i_cfg_index == REG_OUT_CAP))) begin
                r_init_seq  <= cfg_init;
                r_out_cap   <= cfg_cap;
                r_expected  <= cfg_init;
                r_delta     <= '0;
                r_q         <= '0;
                r_rem       <= '0;
                r_credit    <= cfg_credit;
                r_delivered <= '0;
                r_occ       <= '0;
            end else if (i_cmd.emit) begin
                r_credit <= n_credit;
                if (advance) begin
                    r_expected  <= n_expected;
                    r_delivered <= n_delivered;
                    r_delta     <= n_delta;
                    r_q         <= n_q;
                    r_rem       <= n_rem;
                end
                if (i_cmd.kind == KIND_DRAIN) begin
                    r_occ[r_q] <= 1'b0;
                end
                if (i_cmd.kind == KIND_STORE) begin
                    r_occ[slot_calc] <= 1'b1;
                end
            end

            if (i_cmd.capture) begin
                r_peer <= i_peer_advertised_window;
            end

            if (i_cmd.div_start) begin
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_busy <= 1'b0;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_seq      <= i_packet_sequence;
            r_len      <= clamp_len;
            r_win_flag <= (i_peer_advertised_window != r_peer);
        end

        if (i_cmd.div_start) begin
            r_num  <= wrapped ? NUM_W'(seq_off) : NUM_W'(seq_gap + SEQ_W'(r_rem));
            r_base <= wrapped ? '0 : r_q;
        end else if (r_busy) begin
            r_quot <= quot_calc;
        end

        if (i_cmd.emit) begin
            o_result_kind         <= i_cmd.kind;
            o_slot_index          <= slot_ext[SLOT_OUT_W-1:0];
            o_move_length         <= n_move;
            o_write_offset        <= n_offset;
            o_ack_number          <= advance ? n_expected : r_expected;
            o_advertised_space    <= n_credit;
            o_peer_window_changed <= r_win_flag;
            o_last_of_run         <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit && (i_cmd.kind == KIND_STORE)) begin
            r_mem[slot_calc] <= r_len;
        end
        r_rd_len <= r_mem[r_q];
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: hw/rtl/reorder_receive_window.sv
// Reorder receive window: one packet header per transaction in, a run of result transactions out.
// A packet too far ahead is dropped with no result; one ahead in range passes the slot divider
// and the slot stage before its first result. A new packet is accepted only once the previous
// one has emitted its last result. Each drained slot gives a result (slot table read port).
// Each result waits in one output register until taken, and the sequence stalls at its next result.
// Reset (synchronous, active low) restores the configuration defaults and clears all slots.
module reorder_receive_window #(
    parameter int WINDOW_PACKETS = 8,
    parameter int PAYLOAD_BYTES  = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rrw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rrw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [rrw_pkg::SEQ_W-1:0]         i_packet_sequence,
    input  logic [rrw_pkg::LEN_W-1:0]         i_payload_length,
    input  logic [rrw_pkg::WIN_W-1:0]         i_peer_advertised_window,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [rrw_pkg::KIND_W-1:0]        o_result_kind,
    output logic [rrw_pkg::SLOT_OUT_W-1:0]    o_slot_index,
    output logic [rrw_pkg::LEN_W-1:0]         o_move_length,
    output logic [rrw_pkg::SEQ_W-1:0]         o_write_offset,
    output logic [rrw_pkg::SEQ_W-1:0]         o_ack_number,
    output logic [rrw_pkg::CREDIT_W-1:0]      o_advertised_space,
    output logic                              o_peer_window_changed,
    output logic                              o_last_of_run
);
    import rrw_pkg::*;

    t_cmd    cmd;
    t_status status;

    rrw_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rrw_datapath #(
        .WINDOW_PACKETS (WINDOW_PACKETS),
        .PAYLOAD_BYTES  (PAYLOAD_BYTES)
    ) u_dp (
        .i_clk                    (i_clk),
        .i_rst_n                  (i_rst_n),
        .i_cfg_we                 (i_cfg_we),
        .i_cfg_index              (i_cfg_index),
        .i_cfg_data               (i_cfg_data),
        .i_packet_sequence        (i_packet_sequence),
        .i_payload_length         (i_payload_length),
        .i_peer_advertised_window (i_peer_advertised_window),
        .i_cmd                    (cmd),
        .o_status                 (status),
        .i_out_ready              (i_out_ready),
        .o_out_valid              (o_out_valid),
        .o_result_kind            (o_result_kind),
        .o_slot_index             (o_slot_index),
        .o_move_length            (o_move_length),
        .o_write_offset           (o_write_offset),
        .o_ack_number             (o_ack_number),
        .o_advertised_space       (o_advertised_space),
        .o_peer_window_changed    (o_peer_window_changed),
        .o_last_of_run            (o_last_of_run)
    );

endmodule
